// ----- rtl/itoa_pkg.sv -----
`default_nettype none

package itoa_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 5;
   localparam int CHAR_W  = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;
   localparam logic [DIGIT_W-1:0] DEC_DIGITS = 5'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_DIGITS) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/itoa_if.sv -----
`default_nettype none

interface itoa_req_if;
   logic                          valid;
   logic                          ready;
   logic [itoa_pkg::VALUE_W-1:0]  value;
   logic                          is_signed;
   logic [itoa_pkg::RADIX_W-1:0]  radix;

   modport source (output valid, value, is_signed, radix, input ready);
   modport sink   (input valid, value, is_signed, radix, output ready);
endinterface

interface itoa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itoa_pkg::CHAR_W-1:0]   text_char;
   logic                          last_char;
   logic                          bad_radix;

   modport source (output valid, text_char, last_char, bad_radix, input ready);
   modport sink   (input valid, text_char, last_char, bad_radix, output ready);
endinterface

`default_nettype wire

// ----- rtl/integer_to_ascii_radix.sv -----
// Long division by the radix, 8 quotient bits per cycle, yields one digit per pass
// over the value; then the sign character is loaded if the value is negative,
// then each character takes a digit memory read, then an output load.
// One word at a time: a new value is accepted only when idle.
// A bad radix gives its single error word from the error state once the output is free.
// Reset: synchronous; clears control and output valid. The digit memory is not cleared.
`default_nettype none

module integer_to_ascii_radix
#(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
)
(
   input  wire        clock,
   input  wire        reset,
   itoa_req_if.sink   req_if,
   itoa_rsp_if.source rsp_if
);
   import itoa_pkg::*;

   localparam int DIV_BITS = 8;
   localparam int WORK_W   = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int NSTEP    = WORK_W / DIV_BITS;
   localparam int STEP_W   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
   localparam int DEPTH    = VALUE_BITS + 1;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_SIGN = 6'b000100,
      S_RD   = 6'b001000,
      S_EMIT = 6'b010000,
      S_ERR  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [WORK_W-1:0]   work_ff, work_in;
   logic [RADIX_W-1:0]  rem_ff, rem_in;
   logic [RADIX_W-1:0]  radix_ff, radix_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   text_ff, text_in;
   logic                last_ff, last_in;
   logic                bad_ff, bad_in;

   logic [DIGIT_W-1:0]  digit_mem [DEPTH];
   logic [DIGIT_W-1:0]  mem_rd_ff;
   logic                mem_we;
   logic [CNT_W-1:0]    cnt_m1;

   logic [VALUE_BITS-1:0] v_in;
   logic                  v_neg;
   logic [VALUE_BITS-1:0] v_mag;
   logic                  radix_bad;
   logic                  req_fire;
   logic                  out_free;
   logic                  last_step;

   logic [RADIX_W-1:0]  rem_div;
   logic [WORK_W-1:0]   work_div;

   assign req_fire  = req_if.valid && req_if.ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign last_step = (step_ff == STEP_W'(NSTEP - 1));
   assign cnt_m1    = cnt_ff - CNT_W'(1);

   assign v_in      = VALUE_BITS'(req_if.value);
   assign v_neg     = req_if.is_signed && v_in[VALUE_BITS-1];
   assign v_mag     = v_neg ? VALUE_BITS'(~v_in + VALUE_BITS'(1)) : v_in;
   assign radix_bad = (req_if.radix < RADIX_MIN) || (req_if.radix > RADIX_MAX);

   // 8 restoring division steps; remainder stays below radix so 6 bits suffice
   always_comb begin
      rem_div  = rem_ff;
      work_div = work_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         rem_div  = {rem_div[RADIX_W-2:0], work_div[WORK_W-1]};
         work_div = {work_div[WORK_W-2:0], 1'b0};
         if (rem_div >= radix_ff) begin
            rem_div     = rem_div - radix_ff;
            work_div[0] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      text_in      = text_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               work_in  = WORK_W'(v_mag);
               rem_in   = '0;
               radix_in = req_if.radix;
               neg_in   = v_neg;
               cnt_in   = '0;
               step_in  = '0;
               state_in = radix_bad ? S_ERR : S_DIV;
            end
         end
         S_DIV: begin
            work_in = work_div;
            rem_in  = rem_div;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               // quotient done: store remainder digit, go again on a nonzero quotient
               mem_we  = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
               rem_in  = '0;
               step_in = '0;
               if (work_div == '0) begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            if (!neg_ff) begin
               state_in = S_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               text_in      = CHAR_MINUS;
               last_in      = 1'b0;
               bad_in       = 1'b0;
               state_in     = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               text_in      = digit_char(mem_rd_ff);
               last_in      = (cnt_ff == CNT_W'(1));
               bad_in       = 1'b0;
               cnt_in       = cnt_m1;
               state_in     = (cnt_ff == CNT_W'(1)) ? S_IDLE : S_RD;
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               text_in      = CHAR_NONE;
               last_in      = 1'b1;
               bad_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
      text_ff  <= text_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
   end

   // digit memory, least significant digit at address 0
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[cnt_ff[ADDR_W-1:0]] <= rem_div[DIGIT_W-1:0];
      end
      mem_rd_ff <= digit_mem[cnt_m1[ADDR_W-1:0]];
   end

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.text_char = text_ff;
   assign rsp_if.last_char = last_ff;
   assign rsp_if.bad_radix = bad_ff;

   a_bad_to_err: assert property (@(posedge clock) disable iff (reset)
      (req_fire && radix_bad) |=> (state_ff == S_ERR))
      else $error("bad radix did not go to error state");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_W'(DEPTH)))
      else $error("digit count beyond memory depth");

   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_EMIT) |-> (cnt_ff != '0))
      else $error("emitting with no digits stored");

   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && bad_ff) |-> (last_ff && text_ff == CHAR_NONE))
      else $error("error word malformed");

endmodule

`default_nettype wire

// ----- verif/integer_to_ascii_radix_tb.sv -----
`timescale 1ns / 100ps

typedef struct packed {
   logic [itoa_pkg::CHAR_W-1:0] text_char;
   logic                        last_char;
   logic                        bad_radix;
} text_word_type;

class text_scoreboard;
   text_word_type                  pending_words[$];
   logic [itoa_pkg::DIGIT_W-1:0]   digit_buf[0:itoa_pkg::VALUE_W];
   int                             digit_total;
   logic [itoa_pkg::VALUE_W-1:0]   magnitude;
   int                             mismatches;

   function int outstanding();
      return pending_words.size();
   endfunction

   function void note_request(logic [itoa_pkg::VALUE_W-1:0] value, logic is_signed,
                              logic [itoa_pkg::RADIX_W-1:0] radix);
      text_word_type                w;
      logic                         negative;
      logic [itoa_pkg::DIGIT_W-1:0] d;
      negative = 1'b0;
      if (radix < itoa_pkg::RADIX_MIN || radix > itoa_pkg::RADIX_MAX) begin
         // bad radix: one error word, digit state untouched
         w.text_char = itoa_pkg::CHAR_NONE;
         w.last_char = 1'b1;
         w.bad_radix = 1'b1;
         pending_words.push_back(w);
         return;
      end
      magnitude = value;
      if (is_signed && value[itoa_pkg::VALUE_W-1]) begin
         negative  = 1'b1;
         magnitude = ~value + 1'b1;
      end
      digit_total = 0;
      do begin
         digit_buf[digit_total] = itoa_pkg::DIGIT_W'(magnitude % 32'(radix));
         digit_total++;
         magnitude = magnitude / 32'(radix);
      end while (magnitude != 0);
      if (negative) begin
         w.text_char = itoa_pkg::CHAR_MINUS;
         w.last_char = 1'b0;
         w.bad_radix = 1'b0;
         pending_words.push_back(w);
      end
      for (int k = digit_total - 1; k >= 0; k--) begin
         d = digit_buf[k];
         w.text_char = (d < itoa_pkg::DEC_DIGITS) ?
                       itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(d) :
                       itoa_pkg::CHAR_A + itoa_pkg::CHAR_W'(d - itoa_pkg::DEC_DIGITS);
         w.last_char = (k == 0);
         w.bad_radix = 1'b0;
         pending_words.push_back(w);
      end
   endfunction

   function void check_word(text_word_type got);
      text_word_type want;
      if (pending_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: unexpected word char=%h last=%b bad=%b",
                     got.text_char, got.last_char, got.bad_radix);
         return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected char=%h last=%b bad=%b, got char=%h last=%b bad=%b",
                     want.text_char, want.last_char, want.bad_radix,
                     got.text_char, got.last_char, got.bad_radix);
      end
   endfunction
endclass

module integer_to_ascii_radix_tb;
   import itoa_pkg::*;

   localparam int RANDOM_ITEMS = 350;
   localparam int CYCLE_LIMIT  = 2500000;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;

   text_scoreboard sb;

   itoa_req_if req_if();
   itoa_rsp_if rsp_if();

   integer_to_ascii_radix dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** integer_to_ascii_radix: FAILED **");
         $finish;
      end
   end

   // half zero gaps, most others short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 6))
         0: return $urandom_range(0, 40);
         1: return 32'h8000_0000 + $urandom_range(0, 8);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 8);
         3: return 32'h7FFF_FFFF - $urandom_range(0, 8);
         4: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [RADIX_W-1:0] pick_radix();
      if ($urandom_range(0, 9) != 0)
         return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      case ($urandom_range(0, 2))
         0: return RADIX_W'(0);
         1: return RADIX_W'(1);
         default: return RADIX_W'($urandom_range(RADIX_MAX + 1, 63));
      endcase
   endfunction

   // valid is left high after accept so back-to-back words need no toggle
   task automatic send_word(logic [VALUE_W-1:0] value, logic is_signed,
                            logic [RADIX_W-1:0] radix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.value     <= value;
      req_if.is_signed <= is_signed;
      req_if.radix     <= radix;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(value, is_signed, radix);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         int n;
         n = pick_gap();
         if (n > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_word({rsp_if.text_char, rsp_if.last_char, rsp_if.bad_radix});
   end

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.value     <= '0;
      req_if.is_signed <= 1'b0;
      req_if.radix     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(32'h0000_0000, 1'b0, 6'd10);
      send_word(32'h0000_0000, 1'b1, 6'd2);
      send_word(32'hFFFF_FFFF, 1'b0, 6'd2);
      send_word(32'hFFFF_FFFF, 1'b1, 6'd2);
      send_word(32'h8000_0000, 1'b1, 6'd2);
      send_word(32'h8000_0000, 1'b1, 6'd10);
      send_word(32'h8000_0000, 1'b1, 6'd32);
      send_word(32'h8000_0000, 1'b0, 6'd16);
      send_word(32'h7FFF_FFFF, 1'b1, 6'd16);
      send_word(32'hFFFF_FFFF, 1'b0, 6'd32);
      send_word(32'hFFFF_FFFF, 1'b0, 6'd10);
      send_word(32'hFFFF_FFFF, 1'b0, 6'd31);
      send_word(32'hDEAD_BEEF, 1'b1, 6'd3);
      send_word(32'd123456789, 1'b0, 6'd36);
      send_word(32'd42, 1'b1, 6'd0);
      send_word(32'd42, 1'b0, 6'd1);
      send_word(32'd42, 1'b0, 6'd33);
      send_word(32'hFFFF_FFFF, 1'b1, 6'd63);
      send_word(32'd35, 1'b0, 6'd36);
      send_word(32'd31, 1'b0, 6'd32);
      send_word(32'd1, 1'b1, 6'd7);
      send_word(32'hFFFF_FFF6, 1'b1, 6'd10);
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain();
         send_word(pick_value(), 1'($urandom_range(0, 1)), pick_radix());
      end
      drain();

      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("** integer_to_ascii_radix: PASSED **");
      end else begin
         $display("** integer_to_ascii_radix: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/itoa_pkg.sv
rtl/itoa_if.sv
rtl/integer_to_ascii_radix.sv
verif/integer_to_ascii_radix_tb.sv
